>>> design/trapezoid_velocity_step_top_macros.svh
// Assertion helpers used by the checker of this block.
// Each macro samples on the rising edge of clk and is switched off while rst_n is low.
`ifndef TRAPEZOID_VELOCITY_STEP_TOP_MACROS_SVH
`define TRAPEZOID_VELOCITY_STEP_TOP_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define TVS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequence must hold in the cycle after the condition.
`define TVS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/tvs_pkg.sv
`timescale 1ns / 1ps

package tvs_pkg;

    // Configuration register indexes, taken from paddr[4:2].
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VELOCITY       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCELERATION       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_TOLERANCE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_TOLERANCE = 3'd4;

    localparam int CFG_W = 31;

    localparam logic [CFG_W-1:0] RST_MAX_VELOCITY       = 31'd65536;
    localparam logic [CFG_W-1:0] RST_ACCELERATION       = 31'd65536;
    localparam logic [CFG_W-1:0] RST_STEP_PERIOD        = 31'd66;
    localparam logic [CFG_W-1:0] RST_POSITION_TOLERANCE = 31'd655;
    localparam logic [CFG_W-1:0] RST_VELOCITY_TOLERANCE = 31'd655;

    // One square root stage per result bit of a 64-bit radicand.
    localparam int SQ_STAGES = 32;

    // Register stages from an accepted item to its strobe: input stage, product,
    // square root, target/difference, clamp, output.
    localparam int LATENCY = SQ_STAGES + 5;

    // Data that rides along with an item through the square root pipeline.
    typedef struct packed {
        logic               err_pos;
        logic               err_neg;
        logic               kill;
        logic               near;
        logic signed [31:0] vel;
    } tvs_side_t;

endpackage

>>> design/tvs_isqrt.sv
`timescale 1ns / 1ps

module tvs_isqrt (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [63:0]         radicand,
    input  tvs_pkg::tvs_side_t  in_side,
    output logic                out_valid,
    output logic [31:0]         root,
    output tvs_pkg::tvs_side_t  out_side
);
    import tvs_pkg::*;

    // Restoring square root, one result bit per stage.
    logic              valid_reg [SQ_STAGES];
    logic [32:0]       rem_reg   [SQ_STAGES];
    logic [31:0]       root_reg  [SQ_STAGES];
    logic [63:0]       rad_reg   [SQ_STAGES];
    tvs_side_t         side_reg  [SQ_STAGES];

    logic [32:0]       rem_src   [SQ_STAGES];
    logic [31:0]       root_src  [SQ_STAGES];
    logic [63:0]       rad_src   [SQ_STAGES];
    logic [34:0]       rem_sh    [SQ_STAGES];
    logic [34:0]       trial     [SQ_STAGES];
    logic [34:0]       diff      [SQ_STAGES];
    logic              bit_set   [SQ_STAGES];
    logic [32:0]       rem_next  [SQ_STAGES];
    logic [31:0]       root_next [SQ_STAGES];
    logic [63:0]       rad_next  [SQ_STAGES];

    always_comb
    begin
        rem_src[0]  = '0;
        root_src[0] = '0;
        rad_src[0]  = radicand;
        for (int k = 1; k < SQ_STAGES; k++)
        begin
            rem_src[k]  = rem_reg[k-1];
            root_src[k] = root_reg[k-1];
            rad_src[k]  = rad_reg[k-1];
        end
        for (int k = 0; k < SQ_STAGES; k++)
        begin
            rem_sh[k]    = {rem_src[k], rad_src[k][63:62]};
            trial[k]     = {1'b0, root_src[k], 2'b01};
            diff[k]      = rem_sh[k] - trial[k];
            bit_set[k]   = (rem_sh[k] >= trial[k]);
            rem_next[k]  = bit_set[k] ? diff[k][32:0] : rem_sh[k][32:0];
            root_next[k] = {root_src[k][30:0], bit_set[k]};
            rad_next[k]  = {rad_src[k][61:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SQ_STAGES; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < SQ_STAGES; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= in_side;
        for (int k = 1; k < SQ_STAGES; k++)
        begin
            side_reg[k] <= side_reg[k-1];
        end
        for (int k = 0; k < SQ_STAGES; k++)
        begin
            rem_reg[k]  <= rem_next[k];
            root_reg[k] <= root_next[k];
            rad_reg[k]  <= rad_next[k];
        end
    end

    assign out_valid = valid_reg[SQ_STAGES-1];
    assign root      = root_reg[SQ_STAGES-1];
    assign out_side  = side_reg[SQ_STAGES-1];

endmodule

>>> design/trapezoid_velocity_step_top.sv
`timescale 1ns / 1ps

// One step of an online trapezoidal velocity profile, for one axis sample per item.
// An item is handed over with start while busy is low; busy never rises, so a new
// item may follow in every cycle and many axes can share the block in turn.
// Each item carries goal_position, present_position and present_velocity (signed
// Q16.16). The result, velocity_command, is marked by a one-cycle done strobe once
// the item has left the input, product, square root, target, clamp and output stages.
// Items leave in the order they came.
// The latency is set by the square root of 2*acceleration*distance, which is built
// as a 32-stage pipeline with one result bit per stage; the remaining five stages
// form the error, the product, the target difference, the clamp and the output.
// The receiver cannot stall the block, so no back pressure exists anywhere.
// The limits live in five registers on an APB-style port at byte addresses 0 to 16.
// Reset loads their default values and empties the pipeline, so no done strobe
// follows for an item that was in flight. Registers are to be rewritten by the user
// only while the block holds no item in flight; the block does not enforce it.
module trapezoid_velocity_step_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] goal_position,
    input  logic signed [31:0] present_position,
    input  logic signed [31:0] present_velocity,
    output logic               done,
    output logic signed [31:0] velocity_command
);
    import tvs_pkg::*;

    // Configuration registers.
    logic [CFG_W-1:0] max_velocity_reg;
    logic [CFG_W-1:0] acceleration_reg;
    logic [CFG_W-1:0] step_period_reg;
    logic [CFG_W-1:0] position_tolerance_reg;
    logic [CFG_W-1:0] velocity_tolerance_reg;

    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_idx;

    assign pready    = 1'b1;
    assign busy      = 1'b0;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_velocity_reg       <= RST_MAX_VELOCITY;
            acceleration_reg       <= RST_ACCELERATION;
            step_period_reg        <= RST_STEP_PERIOD;
            position_tolerance_reg <= RST_POSITION_TOLERANCE;
            velocity_tolerance_reg <= RST_VELOCITY_TOLERANCE;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_MAX_VELOCITY:       max_velocity_reg       <= pwdata[CFG_W-1:0];
                REG_ACCELERATION:       acceleration_reg       <= pwdata[CFG_W-1:0];
                REG_STEP_PERIOD:        step_period_reg        <= pwdata[CFG_W-1:0];
                REG_POSITION_TOLERANCE: position_tolerance_reg <= pwdata[CFG_W-1:0];
                REG_VELOCITY_TOLERANCE: velocity_tolerance_reg <= pwdata[CFG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_MAX_VELOCITY:       prdata = {1'b0, max_velocity_reg};
            REG_ACCELERATION:       prdata = {1'b0, acceleration_reg};
            REG_STEP_PERIOD:        prdata = {1'b0, step_period_reg};
            REG_POSITION_TOLERANCE: prdata = {1'b0, position_tolerance_reg};
            REG_VELOCITY_TOLERANCE: prdata = {1'b0, velocity_tolerance_reg};
            default:                prdata = '0;
        endcase
    end

    // The largest velocity change per step depends on the registers alone, so it is
    // kept ready in a register of its own. It is read only several stages after an
    // item enters, which leaves it settled after any register write.
    logic [61:0] step_product;
    logic [45:0] dv_max_reg;

    assign step_product = {31'd0, acceleration_reg} * {31'd0, step_period_reg};

    always_ff @(posedge clk)
    begin
        dv_max_reg <= step_product[61:16];
    end

    // Input stage: position error, its magnitude, and the early exits. A zero limit
    // register or an axis already at rest kills the item; the item still travels
    // down the pipeline so that its strobe keeps the fixed latency.
    logic signed [32:0] err_next;
    logic [32:0]        err_mag;
    logic [31:0]        dist_next;
    logic [31:0]        vel_mag;
    logic               zero_limit;
    logic               near_next;
    tvs_side_t          side_next;

    assign err_next  = {goal_position[31], goal_position}
                     - {present_position[31], present_position};
    assign err_mag   = err_next[32] ? (33'd0 - $unsigned(err_next)) : $unsigned(err_next);
    assign dist_next = err_mag[31:0];
    assign vel_mag   = present_velocity[31] ? (32'd0 - $unsigned(present_velocity))
                                            : $unsigned(present_velocity);

    assign zero_limit = (max_velocity_reg == '0) || (acceleration_reg == '0)
                     || (step_period_reg == '0);
    assign near_next  = (dist_next < {1'b0, position_tolerance_reg});

    always_comb
    begin
        side_next.err_pos = !err_next[32] && (err_next != '0);
        side_next.err_neg = err_next[32];
        side_next.near    = near_next;
        side_next.kill    = zero_limit
                         || (near_next && (vel_mag < {1'b0, velocity_tolerance_reg}));
        side_next.vel     = present_velocity;
    end

    logic        s0_valid_reg;
    logic [31:0] s0_dist_reg;
    tvs_side_t   s0_side_reg;

    // Product stage: 2*acceleration*distance, exact in 64 bits.
    logic [31:0] accel_x2;
    logic [63:0] product_next;
    logic        s1_valid_reg;
    logic [63:0] s1_product_reg;
    tvs_side_t   s1_side_reg;

    assign accel_x2     = {acceleration_reg, 1'b0};
    assign product_next = {32'd0, accel_x2} * {32'd0, s0_dist_reg};

    // Square root pipeline.
    logic        sq_valid;
    logic [31:0] sq_root;
    tvs_side_t   sq_side;

    tvs_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg),
        .radicand  (s1_product_reg),
        .in_side   (s1_side_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    // Target stage: cap the braking speed, give it the sign of the error and take
    // the difference to the present velocity.
    logic [30:0]        mag_next;
    logic signed [31:0] target_next;
    logic signed [32:0] dv_next;

    assign mag_next = (sq_root < {1'b0, max_velocity_reg}) ? sq_root[30:0]
                                                          : max_velocity_reg;

    always_comb
    begin
        if (sq_side.err_pos)
        begin
            target_next = $signed({1'b0, mag_next});
        end
        else if (sq_side.err_neg)
        begin
            target_next = -$signed({1'b0, mag_next});
        end
        else
        begin
            target_next = '0;
        end
    end

    assign dv_next = {target_next[31], target_next} - {sq_side.vel[31], sq_side.vel};

    logic               sa_valid_reg;
    logic signed [32:0] sa_dv_reg;
    logic signed [31:0] sa_vel_reg;
    logic               sa_kill_reg;
    logic               sa_near_reg;

    // Clamp stage: limit the change to plus or minus dv_max and apply it.
    logic signed [47:0] dv_lim;
    logic signed [47:0] dv_ext;
    logic signed [47:0] dv_clamped;
    logic signed [33:0] stepped_vel_next;

    assign dv_lim = $signed({2'b00, dv_max_reg});
    assign dv_ext = {{15{sa_dv_reg[32]}}, sa_dv_reg};

    always_comb
    begin
        if (dv_ext > dv_lim)
        begin
            dv_clamped = dv_lim;
        end
        else if (dv_ext < -dv_lim)
        begin
            dv_clamped = -dv_lim;
        end
        else
        begin
            dv_clamped = dv_ext;
        end
    end

    assign stepped_vel_next = {{2{sa_vel_reg[31]}}, sa_vel_reg}
                            + {dv_clamped[32], dv_clamped[32:0]};

    logic               sb_valid_reg;
    logic signed [33:0] sb_next_reg;
    logic               sb_kill_reg;
    logic               sb_near_reg;

    // Output stage: give zero for a killed item, settle to zero inside the position window
    // once the speed has dropped below one step, and otherwise saturate to 32 bits.
    logic [33:0]        next_mag;
    logic               settle;
    logic signed [31:0] sat_next;
    logic signed [31:0] velocity_command_next;

    assign next_mag = sb_next_reg[33] ? (34'd0 - $unsigned(sb_next_reg))
                                      : $unsigned(sb_next_reg);
    assign settle   = sb_near_reg && ({12'd0, next_mag} < dv_max_reg);

    always_comb
    begin
        if (sb_next_reg > 34'sh0_7FFF_FFFF)
        begin
            sat_next = 32'sh7FFF_FFFF;
        end
        else if (sb_next_reg < -34'sh0_8000_0000)
        begin
            sat_next = 32'sh8000_0000;
        end
        else
        begin
            sat_next = sb_next_reg[31:0];
        end
    end

    assign velocity_command_next = (sb_kill_reg || settle) ? 32'sd0 : sat_next;

    logic               done_reg;
    logic signed [31:0] velocity_command_reg;

    // Valid bits of every stage clear at reset; the data registers need no reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            sa_valid_reg <= 1'b0;
            sb_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= start && !busy;
            s1_valid_reg <= s0_valid_reg;
            sa_valid_reg <= sq_valid;
            sb_valid_reg <= sa_valid_reg;
            done_reg     <= sb_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_dist_reg          <= dist_next;
        s0_side_reg          <= side_next;
        s1_product_reg       <= product_next;
        s1_side_reg          <= s0_side_reg;
        sa_dv_reg            <= dv_next;
        sa_vel_reg           <= sq_side.vel;
        sa_kill_reg          <= sq_side.kill;
        sa_near_reg          <= sq_side.near;
        sb_next_reg          <= stepped_vel_next;
        sb_kill_reg          <= sa_kill_reg;
        sb_near_reg          <= sa_near_reg;
        velocity_command_reg <= velocity_command_next;
    end

    assign done             = done_reg;
    assign velocity_command = velocity_command_reg;

endmodule

>>> design/tvs_checker.sv
`timescale 1ns / 1ps

`include "trapezoid_velocity_step_top_macros.svh"

module tvs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [4:0]         paddr,
    input logic [31:0]        pwdata,
    input logic [31:0]        prdata,
    input logic               pready,
    input logic               start,
    input logic               busy,
    input logic signed [31:0] goal_position,
    input logic signed [31:0] present_position,
    input logic signed [31:0] present_velocity,
    input logic               done,
    input logic signed [31:0] velocity_command
);
    import tvs_pkg::*;

    // Shadow lines that follow each taken item to its strobe.
    logic [LATENCY-1:0] acc_line_reg;
    logic [LATENCY-1:0] zero_line_reg;
    logic               at_rest;

    // An item standing on its goal with no speed must be answered with zero.
    assign at_rest = (goal_position == present_position) && (present_velocity == 32'sd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_line_reg  <= '0;
            zero_line_reg <= '0;
        end
        else
        begin
            acc_line_reg  <= {acc_line_reg[LATENCY-2:0], start && !busy};
            zero_line_reg <= {zero_line_reg[LATENCY-2:0], start && !busy && at_rest};
        end
    end

    `TVS_ASSERT_NOW(a_done_latency, 1'b1, done == acc_line_reg[LATENCY-1], "done strobe does not match an item taken at fixed latency")
    `TVS_ASSERT_NOW(a_zero_at_rest, done && zero_line_reg[LATENCY-1], velocity_command == 32'sd0, "item at rest on its goal gave a nonzero command")
    `TVS_ASSERT_NOW(a_never_busy, 1'b1, !busy && pready, "block refused an item or a register access")
    `TVS_ASSERT_NEXT(a_cfg_readback, psel && penable && pwrite && paddr[4:2] <= REG_VELOCITY_TOLERANCE, !(psel && !pwrite && paddr == $past(paddr)) || (prdata[30:0] == $past(pwdata[30:0]) && !prdata[31]), "register read after write returned other data")

endmodule

bind trapezoid_velocity_step_top tvs_checker u_tvs_checker (.*);
